// ===== hw/rtl/gbn_pkg.sv =====
// Shared types and constants for the go-back-N sender window core.
// Holds request codes, register indexes, reset values and the control/status structs.
// No dependencies.
package gbn_pkg;

   localparam int SEQ_W      = 16;
   localparam int ACK_W      = 32;
   localparam int REQ_W      = 2;
   localparam int WIN_CFG_W  = 4;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_ACK   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_START = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_TOTAL   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT = 2'd2;

   localparam logic [ACK_W-1:0]     ACK_NONE      = 32'hFFFF_FFFF;
   localparam logic [SEQ_W-1:0]     TOTAL_RESET   = 16'd0;
   localparam logic [WIN_CFG_W-1:0] WINDOW_RESET  = 4'd4;
   localparam logic [SEQ_W-1:0]     TIMEOUT_RESET = 16'd500;
   localparam logic [SEQ_W-1:0]     ELAPSED_MAX   = 16'hFFFF;

   typedef struct packed {
      logic accept;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic emit_last;
   } stat_type;

endpackage

// ===== hw/rtl/gbn_ctrl.sv =====
// Controller for the go-back-N sender window core: idle / emit sequencing.
// Depends on gbn_pkg for the command and status structs.
module gbn_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gbn_pkg::stat_type stat,
   output gbn_pkg::cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff;
   logic state_in;

   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.accept = (state_ff == ST_IDLE) && req_valid;
   assign cmd.emit   = (state_ff == ST_EMIT) && stat.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // return once the final result of the transaction is issued
            if (stat.out_free && stat.emit_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/gbn_datapath.sv =====
// Datapath for the go-back-N sender window core: window state, timer,
// configuration registers and the result register. Depends on gbn_pkg.
module gbn_datapath #(
   parameter int MAX_WINDOW = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gbn_pkg::cmd_type                    cmd,
   output gbn_pkg::stat_type                   stat,
   input  logic [gbn_pkg::REQ_W-1:0]           req_type,
   input  logic [gbn_pkg::ACK_W-1:0]           req_ack_seq,
   input  logic                                csr_wr_en,
   input  logic [gbn_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [gbn_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_send_valid,
   output logic [gbn_pkg::SEQ_W-1:0]           rsp_send_seq,
   output logic                                rsp_is_retransmit,
   output logic [gbn_pkg::SEQ_W-1:0]           rsp_window_base,
   output logic                                rsp_all_acked,
   output logic                                rsp_last
);

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int WIN_W = $clog2(MAX_WINDOW + 1);
   localparam int SW    = gbn_pkg::SEQ_W;

   localparam logic [1:0] MODE_STATUS = 2'd0;
   localparam logic [1:0] MODE_FILL   = 2'd1;
   localparam logic [1:0] MODE_RETX   = 2'd2;

   // configuration
   logic [SW-1:0]                 total_ff, total_in;
   logic [gbn_pkg::WIN_CFG_W-1:0] window_ff, window_in;
   logic [SW-1:0]                 timeout_ff, timeout_in;

   // window and timer state
   logic [SW-1:0]    base_ff, base_in;
   logic [SW-1:0]    next_ff, next_in;
   logic             timer_ff, timer_in;
   logic [SW-1:0]    elapsed_ff, elapsed_in;
   logic [SW-1:0]    cursor_ff, cursor_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [1:0]       mode_ff, mode_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          send_valid_ff, send_valid_in;
   logic [SW-1:0] send_seq_ff, send_seq_in;
   logic          retx_ff, retx_in;
   logic [SW-1:0] wbase_ff, wbase_in;
   logic          acked_ff, acked_in;
   logic          last_ff, last_in;

   logic [WIN_W-1:0] eff_win;
   logic [SW:0]      limit;
   logic [SW:0]      next_inc;
   logic [SW:0]      cursor_inc;
   logic             k_lt_max, k1_lt_max;
   logic             fill_ok, fill_more, retx_ok, retx_more, send_now;
   logic             ack_ok;
   logic [SW-1:0]    ack_base;
   logic [SW-1:0]    tmo_limit;
   logic [SW-1:0]    el_inc;

   always_comb begin
      if (window_ff == '0) begin
         eff_win = WIN_W'(1);
      end else if (32'(window_ff) > MAX_WINDOW) begin
         eff_win = WIN_W'(MAX_WINDOW);
      end else begin
         eff_win = WIN_W'(window_ff);
      end
   end

   assign limit      = {1'b0, base_ff} + (SW+1)'(eff_win);
   assign next_inc   = {1'b0, next_ff} + (SW+1)'(1);
   assign cursor_inc = {1'b0, cursor_ff} + (SW+1)'(1);
   assign k_lt_max   = 32'(k_ff) < MAX_WINDOW;
   assign k1_lt_max  = (32'(k_ff) + 32'd1) < MAX_WINDOW;

   assign fill_ok   = (mode_ff == MODE_FILL) && (next_ff < total_ff)
                      && ({1'b0, next_ff} < limit) && k_lt_max;
   assign fill_more = (next_inc < {1'b0, total_ff}) && (next_inc < limit) && k1_lt_max;
   assign retx_ok   = (mode_ff == MODE_RETX) && (cursor_ff < next_ff) && k_lt_max;
   assign retx_more = (cursor_inc < {1'b0, next_ff}) && k1_lt_max;
   assign send_now  = fill_ok || retx_ok;

   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign stat.emit_last = send_now ? !(fill_ok ? fill_more : retx_more) : 1'b1;

   assign ack_ok    = (req_ack_seq != gbn_pkg::ACK_NONE)
                      && (req_ack_seq >= {16'd0, base_ff})
                      && (req_ack_seq < {16'd0, next_ff});
   assign ack_base  = req_ack_seq[SW-1:0] + SW'(1);
   assign tmo_limit = (timeout_ff == '0) ? SW'(1) : timeout_ff;
   assign el_inc    = (elapsed_ff == gbn_pkg::ELAPSED_MAX) ? elapsed_ff : elapsed_ff + SW'(1);

   always_comb begin
      total_in   = total_ff;
      window_in  = window_ff;
      timeout_in = timeout_ff;
      if (csr_wr_en) begin
         case (csr_addr)
            gbn_pkg::CSR_TOTAL:   total_in   = csr_wdata;
            gbn_pkg::CSR_WINDOW:  window_in  = csr_wdata[gbn_pkg::WIN_CFG_W-1:0];
            gbn_pkg::CSR_TIMEOUT: timeout_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      base_in       = base_ff;
      next_in       = next_ff;
      timer_in      = timer_ff;
      elapsed_in    = elapsed_ff;
      cursor_in     = cursor_ff;
      k_in          = k_ff;
      mode_in       = mode_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      send_valid_in = send_valid_ff;
      send_seq_in   = send_seq_ff;
      retx_in       = retx_ff;
      wbase_in      = wbase_ff;
      acked_in      = acked_ff;
      last_in       = last_ff;

      if (cmd.accept) begin
         k_in    = '0;
         mode_in = MODE_STATUS;
         case (req_type)
            gbn_pkg::REQ_START: begin
               base_in    = '0;
               next_in    = '0;
               timer_in   = 1'b0;
               elapsed_in = '0;
               mode_in    = MODE_FILL;
            end
            gbn_pkg::REQ_ACK: begin
               if (ack_ok) begin
                  base_in    = ack_base;
                  timer_in   = (ack_base != next_ff);
                  elapsed_in = '0;
                  mode_in    = MODE_FILL;
               end
            end
            gbn_pkg::REQ_TICK: begin
               if (timer_ff) begin
                  if (el_inc >= tmo_limit) begin
                     elapsed_in = '0;
                     cursor_in  = base_ff;
                     mode_in    = MODE_RETX;
                  end else begin
                     elapsed_in = el_inc;
                  end
               end
            end
            default: ;
         endcase
      end

      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         send_valid_in = send_now;
         send_seq_in   = fill_ok ? next_ff : (retx_ok ? cursor_ff : '0);
         retx_in       = retx_ok;
         wbase_in      = base_ff;
         acked_in      = (base_ff >= total_ff);
         last_in       = stat.emit_last;
         if (send_now) k_in = k_ff + CNT_W'(1);
         if (fill_ok) begin
            next_in = next_inc[SW-1:0];
            if (!timer_ff) begin
               timer_in   = 1'b1;
               elapsed_in = '0;
            end
         end
         if (retx_ok) cursor_in = cursor_inc[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= gbn_pkg::TOTAL_RESET;
         window_ff    <= gbn_pkg::WINDOW_RESET;
         timeout_ff   <= gbn_pkg::TIMEOUT_RESET;
         base_ff      <= '0;
         next_ff      <= '0;
         timer_ff     <= 1'b0;
         elapsed_ff   <= '0;
         k_ff         <= '0;
         mode_ff      <= MODE_STATUS;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         window_ff    <= window_in;
         timeout_ff   <= timeout_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         timer_ff     <= timer_in;
         elapsed_ff   <= elapsed_in;
         k_ff         <= k_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff     <= cursor_in;
      send_valid_ff <= send_valid_in;
      send_seq_ff   <= send_seq_in;
      retx_ff       <= retx_in;
      wbase_ff      <= wbase_in;
      acked_ff      <= acked_in;
      last_ff       <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_send_valid    = send_valid_ff;
   assign rsp_send_seq      = send_seq_ff;
   assign rsp_is_retransmit = retx_ff;
   assign rsp_window_base   = wbase_ff;
   assign rsp_all_acked     = acked_ff;
   assign rsp_last          = last_ff;

   a_base_le_next : assert property (@(posedge clock) disable iff (reset)
      base_ff <= next_ff)
      else $error("window base passed next sequence number");

   a_fill_starts_timer : assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && fill_ok) |=> timer_ff)
      else $error("fresh send left the timer stopped");

   a_status_only_first : assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && !send_now) |-> (k_ff == '0))
      else $error("status result issued after sends");

endmodule

// ===== hw/rtl/go_back_n_sender_window_core.sv =====
// Go-back-N sender window core: top level joining controller and datapath.
// Sequence: on accept the controller enters its emit state; the first result is then registered
// once the result register is free, and the response transaction is offered from that register.
// Throughput: an item producing n results (1..MAX_WINDOW) issues them in turn through the single
// result register, each when it is free; response stalls stretch this. No new request is taken meanwhile.
// Reset (synchronous): clears base, next sequence and timer, restores register defaults.
// Depends on gbn_pkg, gbn_ctrl and gbn_datapath.
module go_back_n_sender_window_core #(
   parameter int MAX_WINDOW = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [gbn_pkg::REQ_W-1:0]      req_type,
   input  logic [gbn_pkg::ACK_W-1:0]      req_ack_seq,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_send_valid,
   output logic [gbn_pkg::SEQ_W-1:0]      rsp_send_seq,
   output logic                           rsp_is_retransmit,
   output logic [gbn_pkg::SEQ_W-1:0]      rsp_window_base,
   output logic                           rsp_all_acked,
   output logic                           rsp_last,
   // register write port
   input  logic                           csr_wr_en,
   input  logic [gbn_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [gbn_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // command from the controller, status back from the datapath
   gbn_pkg::cmd_type  cmd;
   gbn_pkg::stat_type stat;

   // The controller takes a request transaction only when idle; it then
   // issues one emit per cycle whenever the result register is free, and
   // returns to idle on the result flagged last.
   gbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath applies start, acknowledgement or tick on accept, then
   // walks fresh sends or retransmissions one per emit.
   gbn_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_type          (req_type),
      .req_ack_seq       (req_ack_seq),
      .csr_wr_en         (csr_wr_en),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_send_valid    (rsp_send_valid),
      .rsp_send_seq      (rsp_send_seq),
      .rsp_is_retransmit (rsp_is_retransmit),
      .rsp_window_base   (rsp_window_base),
      .rsp_all_acked     (rsp_all_acked),
      .rsp_last          (rsp_last)
   );

endmodule
